// ----- hw/rtl/lpl_pkg.sv -----
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared types, constants and helpers of the lookahead peak limiter.
// ----------------------------------------------------------------------------
package lpl_pkg;

    localparam int MAX_DELAY_FRAMES_DEF = 1024;
    localparam int MAX_CHANNELS_DEF     = 8;
    localparam int CHUNK_SLOTS_DEF      = 16;

    localparam int CHUNK_LOOK = 10;

    localparam logic [23:0] GAIN_ONE = 24'h800000;
    localparam logic [23:0] GAIN_MAX = 24'hFFFFFF;

    localparam int NUM_W = 52;
    localparam int DEN_W = 24;

    // The smoothing sum is divided by ten through a reciprocal, which is exact
    // for sums below 2^30.
    localparam int          SMOOTH_SHIFT = 31;
    localparam logic [27:0] SMOOTH_RECIP = 28'd214748365;

    localparam logic [1:0] CFG_CHANNEL_COUNT  = 2'd0;
    localparam logic [1:0] CFG_DELAY_FRAMES   = 2'd1;
    localparam logic [1:0] CFG_RELEASE_FRAMES = 2'd2;

    typedef struct packed {
        logic signed [23:0] sample;
        logic               frame_end;
    } sample_t;

    typedef struct packed {
        logic signed [23:0] out_sample;
        logic               out_frame_end;
    } result_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_LATCH,
        OP_CPOS_INC,
        OP_REL_START,
        OP_REL_DONE,
        OP_LIM_START,
        OP_CAND_START,
        OP_CAND_DONE,
        OP_NEXT_J,
        OP_SLOPE_DONE,
        OP_GAIN_STEP,
        OP_SMOOTH_DONE,
        OP_RD,
        OP_MUL,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic boundary;
        logic first;
        logic peak_zero;
        logic j_last;
        logic out_free;
        logic clr_last;
    } status_t;

    // Division by ten through a reciprocal; exact for values up to 40960.
    function automatic logic [15:0] div10(input logic [15:0] a);
        logic [31:0] p;
        p = 32'(a) * 32'd52429;
        return 16'(p >> 19);
    endfunction

endpackage

// ----- hw/rtl/lpl_ram.sv -----
// ----------------------------------------------------------------------------
// lpl_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lpl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/lpl_div.sv -----
// ----------------------------------------------------------------------------
// lpl_div
// Bit-serial restoring divider, one quotient bit per cycle, signed result
// truncated toward zero.
// ----------------------------------------------------------------------------
module lpl_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [lpl_pkg::NUM_W-1:0]         num_mag,
    input  logic                              negate,
    input  logic [lpl_pkg::DEN_W-1:0]         den,
    output logic                              busy,
    output logic signed [lpl_pkg::NUM_W:0]    quotient
);

    localparam int NW = lpl_pkg::NUM_W;
    localparam int DW = lpl_pkg::DEN_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    quo_reg;
    logic [DW:0]      rem_reg;
    logic [DW-1:0]    den_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [DW:0]      rem_sh;
    logic             fits;

    assign rem_sh = {rem_reg[DW-1:0], quo_reg[NW-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num_mag;
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= negate;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

// ----- hw/rtl/lpl_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpl_ctrl
// Sequencer of the limiter: clearing pass, frame start, slope search and
// per-sample delay, gain and output steps.
// ----------------------------------------------------------------------------
module lpl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  lpl_pkg::status_t status,
    output lpl_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_DECIDE,
        S_REL_WAIT,
        S_J_CHECK,
        S_LIM_WAIT,
        S_CAND_WAIT,
        S_NEXT_J,
        S_SLOPE_FIN,
        S_GAIN_STEP,
        S_SMOOTH_WAIT,
        S_RD,
        S_MUL,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = lpl_pkg::OP_NONE;
        case (state_reg)
            S_CLR:
            begin
                cmd.op = lpl_pkg::OP_CLR;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.op     = lpl_pkg::OP_LATCH;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!status.first)
                begin
                    state_next = S_RD;
                end
                else if (status.boundary)
                begin
                    cmd.op     = lpl_pkg::OP_REL_START;
                    state_next = S_REL_WAIT;
                end
                else
                begin
                    cmd.op     = lpl_pkg::OP_CPOS_INC;
                    state_next = S_GAIN_STEP;
                end
            end
            S_REL_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = lpl_pkg::OP_REL_DONE;
                    state_next = S_J_CHECK;
                end
            end
            S_J_CHECK:
            begin
                if (status.peak_zero)
                begin
                    state_next = S_NEXT_J;
                end
                else
                begin
                    cmd.op     = lpl_pkg::OP_LIM_START;
                    state_next = S_LIM_WAIT;
                end
            end
            S_LIM_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = lpl_pkg::OP_CAND_START;
                    state_next = S_CAND_WAIT;
                end
            end
            S_CAND_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = lpl_pkg::OP_CAND_DONE;
                    state_next = S_NEXT_J;
                end
            end
            S_NEXT_J:
            begin
                if (status.j_last)
                begin
                    state_next = S_SLOPE_FIN;
                end
                else
                begin
                    cmd.op     = lpl_pkg::OP_NEXT_J;
                    state_next = S_J_CHECK;
                end
            end
            S_SLOPE_FIN:
            begin
                cmd.op     = lpl_pkg::OP_SLOPE_DONE;
                state_next = S_GAIN_STEP;
            end
            S_GAIN_STEP:
            begin
                cmd.op     = lpl_pkg::OP_GAIN_STEP;
                state_next = S_SMOOTH_WAIT;
            end
            S_SMOOTH_WAIT:
            begin
                cmd.op     = lpl_pkg::OP_SMOOTH_DONE;
                state_next = S_RD;
            end
            S_RD:
            begin
                cmd.op     = lpl_pkg::OP_RD;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op     = lpl_pkg::OP_MUL;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = lpl_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign sample_stall = (state_reg != S_IDLE);

endmodule

// ----- hw/rtl/lpl_datapath.sv -----
// ----------------------------------------------------------------------------
// lpl_datapath
// Configuration registers, delay store, chunk peaks, gain state, slope
// arithmetic and output register of the limiter.
// ----------------------------------------------------------------------------
module lpl_datapath #(
    parameter int MAX_DELAY_FRAMES = lpl_pkg::MAX_DELAY_FRAMES_DEF,
    parameter int MAX_CHANNELS     = lpl_pkg::MAX_CHANNELS_DEF,
    parameter int CHUNK_SLOTS      = lpl_pkg::CHUNK_SLOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_index,
    input  logic [19:0]      cfg_data,
    input  lpl_pkg::sample_t sample_item,
    input  logic             result_stall,
    output logic             result_valid,
    output lpl_pkg::result_t result_item,
    input  lpl_pkg::cmd_t    cmd,
    output lpl_pkg::status_t status
);

    localparam int DEPTH = MAX_DELAY_FRAMES * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int DLW   = $clog2(MAX_DELAY_FRAMES + 1);
    localparam int WPW   = $clog2(MAX_DELAY_FRAMES);
    localparam int CW    = $clog2(MAX_CHANNELS + 1);
    localparam int CIW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CPW   = $clog2(MAX_DELAY_FRAMES / 10 + 1);
    localparam int SW    = $clog2(CHUNK_SLOTS);
    localparam int NW    = lpl_pkg::NUM_W;
    localparam int DW    = lpl_pkg::DEN_W;

    logic [3:0]  ch_cfg_reg;
    logic [10:0] delay_cfg_reg;
    logic [19:0] release_cfg_reg;

    logic [CIW-1:0]     ci_reg;
    logic [WPW-1:0]     wp_reg;
    logic [CPW-1:0]     cpos_reg;
    logic [SW-1:0]      cn_reg;
    logic [23:0]        rp_reg;
    logic [23:0]        gain_reg;
    logic [23:0]        sg_reg;
    logic signed [31:0] slope_reg;
    logic [23:0]        peaks_reg [CHUNK_SLOTS];
    logic [AW-1:0]      clr_reg;
    logic               out_valid_reg;
    lpl_pkg::result_t   out_reg;

    logic signed [23:0] x_reg;
    logic               fend_reg;
    logic [3:0]         j_reg;
    logic [15:0]        acc_reg;
    logic signed [NW:0] best_reg;
    logic signed [48:0] prod_reg;
    logic [27:0]        smooth_reg;

    logic [DLW-1:0] dl;
    logic [CW-1:0]  nch;
    logic [CPW-1:0] csize;
    logic [SW:0]    slot_sum;
    logic [SW-1:0]  slot;
    logic [23:0]    pk;
    logic [AW-1:0]  addr;
    logic [CIW-1:0] ci_in;

    logic               div_start;
    logic [NW-1:0]      div_mag;
    logic               div_neg;
    logic [DW-1:0]      div_den;
    logic               div_busy;
    logic signed [NW:0] div_q;
    logic signed [NW:0] div_snum;

    logic signed [NW:0] rel_num;
    logic signed [NW:0] cand_num;
    logic [DW-1:0]      divj;
    logic signed [25:0] gain_sum;
    logic [23:0]        gain_new;
    logic [27:0]        smooth_num;
    logic [55:0]        smooth_prod;

    logic signed [24:0] x_ext;
    logic signed [24:0] x_neg;
    logic [23:0]        mag;
    logic signed [48:0] round_sum;
    logic signed [25:0] y_wide;
    logic signed [23:0] y_sat;
    logic               closes;
    logic [WPW:0]       wp_inc;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [23:0]        ram_wdata;
    logic [23:0]        ram_rdata;

    always_comb
    begin
        if (delay_cfg_reg < 11'd10)
        begin
            dl = DLW'(10);
        end
        else if (32'(delay_cfg_reg) > 32'(MAX_DELAY_FRAMES))
        begin
            dl = DLW'(MAX_DELAY_FRAMES);
        end
        else
        begin
            dl = DLW'(delay_cfg_reg);
        end
        if (ch_cfg_reg == 4'd0)
        begin
            nch = CW'(1);
        end
        else if (32'(ch_cfg_reg) > 32'(MAX_CHANNELS))
        begin
            nch = CW'(MAX_CHANNELS);
        end
        else
        begin
            nch = CW'(ch_cfg_reg);
        end
    end

    assign csize    = CPW'(lpl_pkg::div10(16'(dl)));
    assign slot_sum = (SW+1)'(cn_reg) + (SW+1)'(CHUNK_SLOTS - 9) + (SW+1)'(j_reg);
    assign slot     = (slot_sum >= (SW+1)'(CHUNK_SLOTS)) ?
                      SW'(slot_sum - (SW+1)'(CHUNK_SLOTS)) : SW'(slot_sum);
    assign pk       = peaks_reg[slot];
    assign addr     = AW'(32'(wp_reg) * 32'(MAX_CHANNELS) + 32'(ci_reg));
    assign ci_in    = (32'(ci_reg) >= 32'(nch)) ? CIW'(nch - 1'b1) : ci_reg;

    assign rel_num  = ($signed({29'b0, lpl_pkg::GAIN_ONE}) - $signed({29'b0, gain_reg})) <<< 8;
    assign cand_num = ($signed({8'b0, div_q[44:0]}) - $signed({29'b0, gain_reg})) <<< 8;
    assign divj     = DW'(lpl_pkg::div10(acc_reg)) + DW'(1);

    assign gain_sum = $signed({2'b00, gain_reg}) + 26'(slope_reg >>> 8);
    always_comb
    begin
        if (gain_sum < 26'sd0)
        begin
            gain_new = '0;
        end
        else if (gain_sum > $signed({2'b00, lpl_pkg::GAIN_MAX}))
        begin
            gain_new = lpl_pkg::GAIN_MAX;
        end
        else
        begin
            gain_new = gain_sum[23:0];
        end
    end
    assign smooth_num  = 28'(gain_new) + 28'(sg_reg) * 28'd9 + 28'd5;
    assign smooth_prod = {28'b0, smooth_reg} * {28'b0, lpl_pkg::SMOOTH_RECIP};

    always_comb
    begin
        div_start = 1'b0;
        div_snum  = '0;
        div_den   = DW'(1);
        case (cmd.op)
            lpl_pkg::OP_REL_START:
            begin
                div_start = 1'b1;
                div_snum  = rel_num;
                div_den   = (release_cfg_reg == 20'd0) ? DW'(1) : DW'(release_cfg_reg);
            end
            lpl_pkg::OP_LIM_START:
            begin
                div_start = 1'b1;
                div_snum  = (NW+1)'(1) <<< 43;
                div_den   = pk;
            end
            lpl_pkg::OP_CAND_START:
            begin
                div_start = 1'b1;
                div_snum  = cand_num;
                div_den   = divj;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end
    assign div_neg = div_snum < 0;
    assign div_mag = div_neg ? NW'(-div_snum) : NW'(div_snum);

    lpl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num_mag  (div_mag),
        .negate   (div_neg),
        .den      (div_den),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign x_ext     = {x_reg[23], x_reg};
    assign x_neg     = -x_ext;
    assign mag       = x_reg[23] ? x_neg[23:0] : x_reg[23:0];
    assign round_sum = prod_reg + 49'sd4194304;
    assign y_wide    = round_sum[48:23];
    always_comb
    begin
        if (y_wide > 26'sd8388607)
        begin
            y_sat = 24'sh7FFFFF;
        end
        else if (y_wide < -26'sd8388608)
        begin
            y_sat = -24'sd8388608;
        end
        else
        begin
            y_sat = y_wide[23:0];
        end
    end
    assign closes = fend_reg || ((32'(ci_reg) + 1) >= 32'(nch));
    assign wp_inc = (WPW+1)'(wp_reg) + (WPW+1)'(1);

    assign ram_we    = (cmd.op == lpl_pkg::OP_CLR) || (cmd.op == lpl_pkg::OP_MUL);
    assign ram_waddr = (cmd.op == lpl_pkg::OP_CLR) ? clr_reg : addr;
    assign ram_wdata = (cmd.op == lpl_pkg::OP_CLR) ? 24'd0 : x_reg;

    lpl_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.op == lpl_pkg::OP_RD),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_cfg_reg      <= 4'd2;
            delay_cfg_reg   <= 11'd240;
            release_cfg_reg <= 20'd96000;
            ci_reg          <= '0;
            wp_reg          <= '0;
            cpos_reg        <= '0;
            cn_reg          <= '0;
            rp_reg          <= '0;
            gain_reg        <= lpl_pkg::GAIN_ONE;
            sg_reg          <= lpl_pkg::GAIN_ONE;
            slope_reg       <= '0;
            clr_reg         <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < CHUNK_SLOTS; i++)
            begin
                peaks_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    lpl_pkg::CFG_CHANNEL_COUNT:  ch_cfg_reg      <= cfg_data[3:0];
                    lpl_pkg::CFG_DELAY_FRAMES:   delay_cfg_reg   <= cfg_data[10:0];
                    lpl_pkg::CFG_RELEASE_FRAMES: release_cfg_reg <= cfg_data;
                    default:                     ch_cfg_reg      <= ch_cfg_reg;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                lpl_pkg::OP_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                lpl_pkg::OP_LATCH:
                begin
                    ci_reg <= ci_in;
                end
                lpl_pkg::OP_CPOS_INC:
                begin
                    cpos_reg <= cpos_reg + 1'b1;
                end
                lpl_pkg::OP_SLOPE_DONE:
                begin
                    if (best_reg > (NW+1)'(32'sh7FFFFFFF))
                    begin
                        slope_reg <= 32'sh7FFFFFFF;
                    end
                    else if (best_reg < -((NW+1)'(1) <<< 31))
                    begin
                        slope_reg <= 32'sh80000000;
                    end
                    else
                    begin
                        slope_reg <= best_reg[31:0];
                    end
                    peaks_reg[cn_reg] <= rp_reg;
                    cn_reg   <= (32'(cn_reg) == CHUNK_SLOTS - 1) ? '0 : cn_reg + 1'b1;
                    rp_reg   <= '0;
                    cpos_reg <= '0;
                end
                lpl_pkg::OP_GAIN_STEP:
                begin
                    gain_reg <= gain_new;
                end
                lpl_pkg::OP_SMOOTH_DONE:
                begin
                    sg_reg <= smooth_prod[lpl_pkg::SMOOTH_SHIFT +: 24];
                    if (slope_reg > 32'sd0 && gain_reg > lpl_pkg::GAIN_ONE)
                    begin
                        gain_reg  <= lpl_pkg::GAIN_ONE;
                        slope_reg <= '0;
                    end
                end
                lpl_pkg::OP_MUL:
                begin
                    if (mag > rp_reg)
                    begin
                        rp_reg <= mag;
                    end
                end
                lpl_pkg::OP_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    if (closes)
                    begin
                        ci_reg <= '0;
                        wp_reg <= (32'(wp_inc) >= 32'(dl)) ? '0 : WPW'(wp_inc);
                    end
                    else
                    begin
                        ci_reg <= ci_reg + 1'b1;
                    end
                end
                default:
                begin
                    clr_reg <= clr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            lpl_pkg::OP_LATCH:
            begin
                x_reg    <= sample_item.sample;
                fend_reg <= sample_item.frame_end;
            end
            lpl_pkg::OP_REL_START:
            begin
                j_reg   <= '0;
                acc_reg <= 16'(dl);
            end
            lpl_pkg::OP_REL_DONE:
            begin
                best_reg <= div_q;
            end
            lpl_pkg::OP_CAND_DONE:
            begin
                if (div_q < best_reg)
                begin
                    best_reg <= div_q;
                end
            end
            lpl_pkg::OP_NEXT_J:
            begin
                j_reg   <= j_reg + 1'b1;
                acc_reg <= acc_reg + 16'(dl);
            end
            lpl_pkg::OP_GAIN_STEP:
            begin
                smooth_reg <= smooth_num;
            end
            lpl_pkg::OP_MUL:
            begin
                prod_reg <= $signed(ram_rdata) * $signed({1'b0, sg_reg});
            end
            lpl_pkg::OP_OUT:
            begin
                out_reg.out_sample    <= y_sat;
                out_reg.out_frame_end <= closes;
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

    assign status.div_busy  = div_busy;
    assign status.boundary  = 32'(cpos_reg) >= 32'(csize);
    assign status.first     = (ci_reg == '0);
    assign status.peak_zero = (pk == 24'd0);
    assign status.j_last    = (32'(j_reg) == lpl_pkg::CHUNK_LOOK - 1);
    assign status.out_free  = !out_valid_reg || !result_stall;
    assign status.clr_last  = (32'(clr_reg) == DEPTH - 1);

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("Divider started while busy.");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == lpl_pkg::OP_OUT) |=> out_valid_reg)
        else $error("Result register not loaded.");

    a_ci_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == lpl_pkg::OP_MUL) |-> (32'(ci_reg) < 32'(nch)))
        else $error("Channel index out of range at store access.");

endmodule

// ----- hw/rtl/lookahead_peak_limiter.sv -----
// ----------------------------------------------------------------------------
// lookahead_peak_limiter
// Lookahead peak limiter on interleaved Q4.20 samples with Q1.23 gain.
// ----------------------------------------------------------------------------
// After reset the block clears its delay store, one entry per cycle, all
// MAX_DELAY_FRAMES*MAX_CHANNELS entries (8192 by default) before it takes the
// first item. With the result side free, an item that is not the first of its
// frame passes through the latch, decide, read, multiply and output states
// before the next acceptance, and the first item of a frame also passes
// through the gain step and the smoothing. At a chunk boundary the first item
// also runs the slope search on a single bit-serial divider: one release
// division and, for each of ten stored chunk peaks that is not zero, a limit
// and a slope division, each holding the sequencer while the divider is busy.
// A result that is not taken holds the block and its input.
module lookahead_peak_limiter #(
    parameter int MAX_DELAY_FRAMES = lpl_pkg::MAX_DELAY_FRAMES_DEF,
    parameter int MAX_CHANNELS     = lpl_pkg::MAX_CHANNELS_DEF,
    parameter int CHUNK_SLOTS      = lpl_pkg::CHUNK_SLOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [19:0]      cfg_data,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  lpl_pkg::sample_t sample_item,
    output logic             result_valid,
    input  logic             result_stall,
    output lpl_pkg::result_t result_item
);

    lpl_pkg::cmd_t    cmd;
    lpl_pkg::status_t status;

    assign cfg_ready = 1'b1;

    lpl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    lpl_datapath #(
        .MAX_DELAY_FRAMES (MAX_DELAY_FRAMES),
        .MAX_CHANNELS     (MAX_CHANNELS),
        .CHUNK_SLOTS      (CHUNK_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_item  (sample_item),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_item  (result_item),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the lookahead peak limiter. A directed table and
// random frames of interleaved samples are sent under several register
// settings, most of them with random idling on both sides. Every result item
// is compared with an in-order prediction of the delayed, gain-scaled sample.
// ----------------------------------------------------------------------------
module tb;

    localparam int  LIMIT_CYCLES  = 6000000;
    localparam int  SETTLE_CYCLES = 1500;
    localparam int  HOLD_CYCLES   = 3000;
    localparam int  NUM_PHASES    = 7;
    localparam int  PHASE_ITEMS   = 215;
    localparam longint ONE_Q23    = 64'sd8388608;
    localparam int  LINE_DEPTH    = lpl_pkg::MAX_DELAY_FRAMES_DEF * lpl_pkg::MAX_CHANNELS_DEF;

    typedef struct {
        logic [23:0] smp;
        logic        fend;
        bit          typed;
        logic        typed_fend;
    } table_row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic [1:0]  cfg_index = lpl_pkg::CFG_CHANNEL_COUNT;
    logic [19:0] cfg_data = '0;
    logic    sample_valid = 1'b0;
    logic    sample_stall;
    lpl_pkg::sample_t sample_item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    lpl_pkg::result_t result_item;

    lookahead_peak_limiter dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .sample_valid(sample_valid), .sample_stall(sample_stall),
        .sample_item(sample_item),
        .result_valid(result_valid), .result_stall(result_stall),
        .result_item(result_item)
    );

    always #5 clk = ~clk;

    // The predictor state mirrors the state of the block.
    logic [3:0]  m_ch_count;
    logic [10:0] m_delay;
    logic [19:0] m_rel_frames;
    logic signed [23:0] m_line [LINE_DEPTH];
    longint      m_peaks [lpl_pkg::CHUNK_SLOTS_DEF];
    longint      m_run_peak;
    longint      m_gain;
    longint      m_smooth;
    longint      m_slope;
    int          m_cpos, m_cnum, m_wpos, m_chan;

    lpl_pkg::result_t limited_q[$];
    int          errors = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_left = 0;

    function automatic longint floor_div_pow2(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-v + (64'sd1 << s) - 1) >>> s);
    endfunction

    function automatic int unsigned eff_delay();
        if (m_delay < 10) return 10;
        if (m_delay > lpl_pkg::MAX_DELAY_FRAMES_DEF) return lpl_pkg::MAX_DELAY_FRAMES_DEF;
        return 32'(m_delay);
    endfunction

    function automatic void update_slope(int unsigned dl);
        longint rf, best, lim, dv, cand;
        int     p;
        rf = (m_rel_frames == 0) ? 64'sd1 : 64'(m_rel_frames);
        best = ((ONE_Q23 - m_gain) * 256) / rf;
        for (int j = 0; j < 10; j++)
        begin
            p = (m_cnum + lpl_pkg::CHUNK_SLOTS_DEF - 9 + j) % lpl_pkg::CHUNK_SLOTS_DEF;
            if (m_peaks[p] != 0)
            begin
                lim = (64'sd1 << 43) / m_peaks[p];
                dv = ((j + 1) * dl) / 10 + 1;
                cand = ((lim - m_gain) * 256) / dv;
                if (cand < best) best = cand;
            end
        end
        if (best > 64'sd2147483647) best = 64'sd2147483647;
        if (best < -64'sd2147483648) best = -64'sd2147483648;
        m_slope = best;
    endfunction

    function automatic void begin_frame(int unsigned dl);
        if (m_cpos >= dl / 10)
        begin
            update_slope(dl);
            m_peaks[m_cnum] = m_run_peak;
            m_cnum = (m_cnum + 1) % lpl_pkg::CHUNK_SLOTS_DEF;
            m_run_peak = 0;
            m_cpos = 0;
        end
        else
        begin
            m_cpos++;
        end
        m_gain += floor_div_pow2(m_slope, 8);
        if (m_gain < 0) m_gain = 0;
        if (m_gain > 64'sd16777215) m_gain = 64'sd16777215;
        m_smooth = (m_gain + 9 * m_smooth + 5) / 10;
        if (m_slope > 0 && m_gain > ONE_Q23)
        begin
            m_gain = ONE_Q23;
            m_slope = 0;
        end
    endfunction

    function automatic lpl_pkg::result_t limit_sample(lpl_pkg::sample_t s);
        lpl_pkg::result_t r;
        longint      x, held, y, mag;
        int unsigned nch, dl, wp, slot;
        bit          closes;
        x = 64'(s.sample);
        nch = (m_ch_count == 0) ? 1 :
              (m_ch_count > lpl_pkg::MAX_CHANNELS_DEF) ? lpl_pkg::MAX_CHANNELS_DEF :
              32'(m_ch_count);
        dl = eff_delay();
        if (m_chan >= nch) m_chan = nch - 1;
        if (m_chan == 0) begin_frame(dl);
        wp = (m_wpos < lpl_pkg::MAX_DELAY_FRAMES_DEF) ? m_wpos : 0;
        slot = wp * lpl_pkg::MAX_CHANNELS_DEF + m_chan;
        held = 64'(m_line[slot]);
        m_line[slot] = s.sample;
        mag = (x < 0) ? -x : x;
        if (mag > m_run_peak) m_run_peak = mag;
        y = floor_div_pow2(held * m_smooth + (64'sd1 << 22), 23);
        if (y > 64'sd8388607) y = 64'sd8388607;
        if (y < -64'sd8388608) y = -64'sd8388608;
        closes = s.frame_end || (m_chan + 1 >= nch);
        if (closes)
        begin
            m_wpos = (m_wpos + 1 >= dl) ? 0 : m_wpos + 1;
            m_chan = 0;
        end
        else
        begin
            m_chan++;
        end
        r.out_sample = y[23:0];
        r.out_frame_end = closes;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Every accepted result item is checked against the head of the queue.
    always @(posedge clk)
    begin : result_check
        lpl_pkg::result_t want;
        cycles <= cycles + 1;
        if (result_valid && !result_stall)
        begin
            if (limited_q.size() == 0)
            begin
                report_mismatch("unexpected item", result_item.out_sample, 0);
            end
            else
            begin
                want = limited_q.pop_front();
                if (result_item.out_sample !== want.out_sample)
                    report_mismatch("out_sample", result_item.out_sample, want.out_sample);
                if (result_item.out_frame_end !== want.out_frame_end)
                    report_mismatch("out_frame_end", result_item.out_frame_end,
                                    want.out_frame_end);
            end
        end
    end

    // The receiver stalls at random, or for a long counted stretch.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic send_sample(lpl_pkg::sample_t s, bit typed, logic typed_fend);
        lpl_pkg::result_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_item <= s;
        do @(posedge clk); while (sample_stall);
        r = limit_sample(s);
        if (typed)
        begin
            r.out_sample = '0;
            r.out_frame_end = typed_fend;
        end
        limited_q.push_back(r);
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        do @(posedge clk); while (limited_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            lpl_pkg::CFG_CHANNEL_COUNT:  m_ch_count = val[3:0];
            lpl_pkg::CFG_DELAY_FRAMES:   m_delay = val[10:0];
            lpl_pkg::CFG_RELEASE_FRAMES: m_rel_frames = val;
            default: ;
        endcase
    endtask

    function automatic logic [23:0] random_sample();
        case ($urandom_range(0, 4))
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 131071)) - 65536);
            2: return $urandom_range(0, 1) ? 24'(24'h7FFFFF - $urandom_range(0, 4095))
                                           : 24'(24'h800000 + $urandom_range(0, 4095));
            3: return 24'($signed($urandom_range(0, 4194303)) - 2097152);
            default: return 24'($signed($urandom_range(0, 2097151)) - 1048576);
        endcase
    endfunction

    table_row_t stim_table [12] = '{
        '{24'h7FFFFF, 1'b0, 1'b1, 1'b0}, '{24'h800000, 1'b0, 1'b1, 1'b1},
        '{24'h000000, 1'b1, 1'b1, 1'b1}, '{24'h000001, 1'b0, 1'b1, 1'b0},
        '{24'hFFFFFF, 1'b1, 1'b1, 1'b1}, '{24'h400000, 1'b0, 1'b1, 1'b0},
        '{24'hC00000, 1'b0, 1'b1, 1'b1}, '{24'h100000, 1'b1, 1'b1, 1'b1},
        '{24'hF00000, 1'b0, 1'b1, 1'b0}, '{24'h0FFFFF, 1'b1, 1'b1, 1'b1},
        '{24'h555555, 1'b0, 1'b1, 1'b0}, '{24'hAAAAAA, 1'b1, 1'b1, 1'b1}
    };

    int          ph_channels [NUM_PHASES] = '{1, 0, 8, 15, 3, 4, 2};
    int          ph_delay    [NUM_PHASES] = '{10, 5, 1024, 2047, 10, 30, 240};
    int          ph_release  [NUM_PHASES] = '{1, 0, 1048575, 50, 1000, 200, 96000};

    initial
    begin
        lpl_pkg::sample_t s;
        m_ch_count = 2;
        m_delay = 240;
        m_rel_frames = 96000;
        foreach (m_line[i]) m_line[i] = '0;
        foreach (m_peaks[i]) m_peaks[i] = 0;
        m_run_peak = 0;
        m_gain = ONE_Q23;
        m_smooth = ONE_Q23;
        m_slope = 0;
        m_cpos = 0;
        m_cnum = 0;
        m_wpos = 0;
        m_chan = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            s.sample = stim_table[i].smp;
            s.frame_end = stim_table[i].fend;
            send_sample(s, stim_table[i].typed, stim_table[i].typed_fend);
        end
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph < 3)
            begin
                send_idle_pct = 23;
                recv_stall_pct = 77;
            end
            else if (ph < 5)
            begin
                send_idle_pct = 77;
                recv_stall_pct = 23;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            write_reg(lpl_pkg::CFG_CHANNEL_COUNT, 20'(ph_channels[ph]));
            write_reg(lpl_pkg::CFG_DELAY_FRAMES, 20'(ph_delay[ph]));
            write_reg(lpl_pkg::CFG_RELEASE_FRAMES, 20'(ph_release[ph]));
            if (ph == 0)
            begin
                foreach (stim_table[i])
                begin
                    s.sample = stim_table[i].smp;
                    s.frame_end = stim_table[i].fend;
                    send_sample(s, 1'b0, 1'b0);
                end
            end
            if (ph == 5) hold_left = HOLD_CYCLES;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                s.sample = random_sample();
                s.frame_end = ($urandom_range(0, 9) == 0);
                send_sample(s, 1'b0, 1'b0);
            end
            drain();
        end

        if (errors == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
